FILE: sv/crd_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// crd_pkg: shared types and constants for the camera ray direction block.
// Widths of the coordinate, basis, scale and normalization datapaths.
// ============================================================================
package crd_pkg;

    // Field and register widths.
    localparam int COORD_BITS    = 13;
    localparam int FRAC_BITS     = 14;
    localparam int COMP_BITS     = FRAC_BITS + 2;
    localparam int BASIS_BITS    = 3 * COMP_BITS;
    localparam int SCALE_BITS    = 24;
    localparam int HALF_BITS     = 13;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = BASIS_BITS;

    // Front-end datapath widths.
    localparam int DIFF_BITS = ((COORD_BITS > HALF_BITS) ? COORD_BITS : HALF_BITS) + 1;
    localparam int AB_BITS   = SCALE_BITS + DIFF_BITS + 1;
    localparam int D_BITS    = AB_BITS + COMP_BITS + 1;
    localparam int MAG_BITS  = D_BITS - 1;
    localparam int POS_BITS  = $clog2(MAG_BITS);

    // The largest normalized magnitude of a nonzero vector lies in [2^(NORM_BITS-1), 2^NORM_BITS).
    localparam int NORM_BITS = 30;
    localparam int NORM_TOP  = NORM_BITS - 1;
    localparam int SQ_BITS   = 2 * NORM_BITS + 2;

    // Square root pipeline.
    localparam int ROOT_BITS  = SQ_BITS / 2;
    localparam int SQ_STEP    = 2;
    localparam int SQ_STAGES  = (ROOT_BITS + SQ_STEP - 1) / SQ_STEP;
    localparam int SQ_WIDE    = 2 * ROOT_BITS + 2;

    // Divider pipeline.
    localparam int Q_BITS     = FRAC_BITS + 1;
    localparam int DV_STEP    = 2;
    localparam int DV_STAGES  = (Q_BITS + DV_STEP - 1) / DV_STEP;
    localparam int NUM_BITS   = NORM_BITS + FRAC_BITS + 1;
    localparam int DREM_BITS  = NUM_BITS + 1;

    localparam logic [Q_BITS-1:0] Q_ONE = Q_BITS'(1) << FRAC_BITS;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_BASIS_RIGHT = 3'd0,
        REG_BASIS_UP    = 3'd1,
        REG_BASIS_BACK  = 3'd2,
        REG_SCALE_H     = 3'd3,
        REG_SCALE_V     = 3'd4,
        REG_HALF_W      = 3'd5,
        REG_HALF_H      = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic [BASIS_BITS-1:0] basis_right;
        logic [BASIS_BITS-1:0] basis_up;
        logic [BASIS_BITS-1:0] basis_back;
        logic [SCALE_BITS-1:0] scale_horizontal;
        logic [SCALE_BITS-1:0] scale_vertical;
        logic [HALF_BITS-1:0]  half_width;
        logic [HALF_BITS-1:0]  half_height;
    } t_cfg;

    // Per-item flags carried alongside the data.
    typedef struct packed {
        logic       zero;
        logic [2:0] neg;
    } t_side;

    typedef logic [2:0][NORM_BITS-1:0] t_norm_vec;

    // Extracts signed component i from a packed basis vector.
    function automatic logic signed [COMP_BITS-1:0] get_comp(
        input logic [BASIS_BITS-1:0] b,
        input int unsigned           i
    );
        return $signed(b[i*COMP_BITS +: COMP_BITS]);
    endfunction

endpackage

FILE: sv/crd_if.sv
`timescale 1ns / 1ps
// ============================================================================
// crd_if: pixel and direction channels of the camera ray direction block.
// Valid/ready handshake with the payload fields of each channel.
// ============================================================================
interface crd_pix_if import crd_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] pixel_row;
    logic [COORD_BITS-1:0] pixel_col;

    modport source (output valid, pixel_row, pixel_col, input ready);
    modport sink   (input valid, pixel_row, pixel_col, output ready);
endinterface

interface crd_dir_if import crd_pkg::*; ();
    logic                        valid;
    logic                        ready;
    logic signed [COMP_BITS-1:0] dir_x;
    logic signed [COMP_BITS-1:0] dir_y;
    logic signed [COMP_BITS-1:0] dir_z;

    modport source (output valid, dir_x, dir_y, dir_z, input ready);
    modport sink   (input valid, dir_x, dir_y, dir_z, output ready);
endinterface

FILE: sv/crd_front.sv
`timescale 1ns / 1ps
// ============================================================================
// crd_front: direction vector, normalization shift and sum of squares.
// Eight register stages from pixel coordinate to the squared length.
// ============================================================================
module crd_front import crd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_vld,
    input  logic [COORD_BITS-1:0] i_row,
    input  logic [COORD_BITS-1:0] i_col,
    input  t_cfg                  i_cfg,
    output logic                  o_vld,
    output logic [SQ_BITS-1:0]    o_sum,
    output t_norm_vec             o_mag,
    output t_side                 o_side
);

    logic [7:0] r_vld;

    logic signed [DIFF_BITS-1:0] r1_dcol, r1_drow;
    logic signed [AB_BITS-1:0]   r2_alpha, r2_beta;
    logic signed [D_BITS-1:0]    r3_pa [3];
    logic signed [D_BITS-1:0]    r3_pb [3];
    logic [2:0][MAG_BITS-1:0]    r4_mag, r5_mag;
    logic [2:0]                  r4_neg;
    t_side                       r5_side, r6_side, r7_side, r8_side;
    logic [POS_BITS-1:0]         r5_pos;
    t_norm_vec                   r6_mag, r7_mag, r8_mag;
    logic [2:0][2*NORM_BITS-1:0] r7_sq;
    logic [SQ_BITS-1:0]          r8_sum;

    logic [2:0][MAG_BITS-1:0]    n4_mag;
    logic [2:0]                  n4_neg;
    logic [POS_BITS-1:0]         n5_pos;
    logic                        n5_zero;
    t_norm_vec                   n6_mag;

    // Valid bits advance with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[6:0], i_vld};
        end
    end

    // Stage 4: signed direction component and its magnitude.
    always_comb begin
        logic signed [D_BITS-1:0] d;
        for (int i = 0; i < 3; i++) begin
            d = r3_pa[i] + r3_pb[i]
              - (D_BITS'(get_comp(i_cfg.basis_back, i)) <<< SCALE_BITS);
            n4_neg[i] = d[D_BITS-1];
            n4_mag[i] = n4_neg[i] ? MAG_BITS'(-d) : MAG_BITS'(d);
        end
    end

    // Stage 5: leading one of the largest magnitude.
    always_comb begin
        logic [MAG_BITS-1:0] orv;
        orv    = r4_mag[0] | r4_mag[1] | r4_mag[2];
        n5_pos = '0;
        for (int b = 0; b < MAG_BITS; b++) begin
            if (orv[b]) n5_pos = POS_BITS'(b);
        end
        n5_zero = (orv == '0);
    end

    // Stage 6: shift all magnitudes together to the normalized range.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (r5_pos > POS_BITS'(NORM_TOP)) begin
                n6_mag[i] = NORM_BITS'(r5_mag[i] >> (r5_pos - POS_BITS'(NORM_TOP)));
            end else begin
                n6_mag[i] = NORM_BITS'(r5_mag[i] << (POS_BITS'(NORM_TOP) - r5_pos));
            end
        end
    end

    // Pipeline registers.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_dcol  <= DIFF_BITS'(i_col) - DIFF_BITS'(i_cfg.half_width);
            r1_drow  <= DIFF_BITS'(i_cfg.half_height) - DIFF_BITS'(i_row);
            r2_alpha <= -(AB_BITS'($signed({1'b0, i_cfg.scale_horizontal}))
                          * AB_BITS'(r1_dcol));
            r2_beta  <= AB_BITS'($signed({1'b0, i_cfg.scale_vertical}))
                          * AB_BITS'(r1_drow);
            for (int i = 0; i < 3; i++) begin
                r3_pa[i] <= D_BITS'(r2_alpha) * D_BITS'(get_comp(i_cfg.basis_right, i));
                r3_pb[i] <= D_BITS'(r2_beta) * D_BITS'(get_comp(i_cfg.basis_up, i));
            end
            r4_mag       <= n4_mag;
            r4_neg       <= n4_neg;
            r5_mag       <= r4_mag;
            r5_pos       <= n5_pos;
            r5_side.neg  <= r4_neg;
            r5_side.zero <= n5_zero;
            r6_mag       <= n6_mag;
            r6_side      <= r5_side;
            for (int i = 0; i < 3; i++) begin
                r7_sq[i] <= r6_mag[i] * r6_mag[i];
            end
            r7_mag  <= r6_mag;
            r7_side <= r6_side;
            r8_sum  <= SQ_BITS'(r7_sq[0]) + SQ_BITS'(r7_sq[1]) + SQ_BITS'(r7_sq[2]);
            r8_mag  <= r7_mag;
            r8_side <= r7_side;
        end
    end

    assign o_vld  = r_vld[7];
    assign o_sum  = r8_sum;
    assign o_mag  = r8_mag;
    assign o_side = r8_side;

endmodule

FILE: sv/crd_isqrt.sv
`timescale 1ns / 1ps
// ============================================================================
// crd_isqrt: pipelined integer square root, two result bits per stage.
// Carries the normalized magnitudes and flags alongside.
// ============================================================================
module crd_isqrt import crd_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_vld,
    input  logic [SQ_BITS-1:0]   i_sum,
    input  t_norm_vec            i_mag,
    input  t_side                i_side,
    output logic                 o_vld,
    output logic [ROOT_BITS-1:0] o_root,
    output t_norm_vec            o_mag,
    output t_side                o_side
);

    logic                 w_vld  [SQ_STAGES+1];
    logic [SQ_BITS-1:0]   w_rem  [SQ_STAGES+1];
    logic [ROOT_BITS-1:0] w_root [SQ_STAGES+1];
    t_norm_vec            w_mag  [SQ_STAGES+1];
    t_side                w_side [SQ_STAGES+1];

    assign w_vld[0]  = i_vld;
    assign w_rem[0]  = i_sum;
    assign w_root[0] = '0;
    assign w_mag[0]  = i_mag;
    assign w_side[0] = i_side;

    for (genvar j = 0; j < SQ_STAGES; j++) begin : g_stage
        logic                 r_vld;
        logic [SQ_BITS-1:0]   r_rem,  n_rem;
        logic [ROOT_BITS-1:0] r_root, n_root;
        t_norm_vec            r_mag;
        t_side                r_side;

        // Try each result bit: keep it while the remainder covers the increase.
        always_comb begin
            int                 k;
            logic [SQ_WIDE-1:0] t;
            n_rem  = w_rem[j];
            n_root = w_root[j];
            for (int b = 0; b < SQ_STEP; b++) begin
                k = ROOT_BITS - 1 - j * SQ_STEP - b;
                t = '0;
                if (k >= 0) begin
                    t = (SQ_WIDE'(n_root) << (k + 1)) + (SQ_WIDE'(1) << (2 * k));
                    if (SQ_WIDE'(n_rem) >= t) begin
                        n_rem  = n_rem - SQ_BITS'(t);
                        n_root = n_root | (ROOT_BITS'(1) << k);
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else if (i_en) begin
                r_vld <= w_vld[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem  <= n_rem;
                r_root <= n_root;
                r_mag  <= w_mag[j];
                r_side <= w_side[j];
            end
        end

        assign w_vld[j+1]  = r_vld;
        assign w_rem[j+1]  = r_rem;
        assign w_root[j+1] = r_root;
        assign w_mag[j+1]  = r_mag;
        assign w_side[j+1] = r_side;
    end

    assign o_vld  = w_vld[SQ_STAGES];
    assign o_root = w_root[SQ_STAGES];
    assign o_mag  = w_mag[SQ_STAGES];
    assign o_side = w_side[SQ_STAGES];

endmodule

FILE: sv/crd_div.sv
`timescale 1ns / 1ps
// ============================================================================
// crd_div: three pipelined restoring dividers, two quotient bits per stage.
// Computes round(mag * 2^FRAC_BITS / root) for each component.
// ============================================================================
module crd_div import crd_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_vld,
    input  logic [ROOT_BITS-1:0]   i_root,
    input  t_norm_vec              i_mag,
    input  t_side                  i_side,
    output logic                   o_vld,
    output logic [2:0][Q_BITS-1:0] o_q,
    output t_side                  o_side
);

    logic                     w_vld  [DV_STAGES+1];
    logic [2:0][NUM_BITS-1:0] w_rem  [DV_STAGES+1];
    logic [2:0][Q_BITS-1:0]   w_q    [DV_STAGES+1];
    logic [ROOT_BITS-1:0]     w_root [DV_STAGES+1];
    t_side                    w_side [DV_STAGES+1];

    // Numerator with half the divisor added for round half up.
    for (genvar i = 0; i < 3; i++) begin : g_num
        assign w_rem[0][i] = (NUM_BITS'(i_mag[i]) << FRAC_BITS)
                           + NUM_BITS'(i_root >> 1);
    end
    assign w_vld[0]  = i_vld;
    assign w_q[0]    = '0;
    assign w_root[0] = i_root;
    assign w_side[0] = i_side;

    for (genvar j = 0; j < DV_STAGES; j++) begin : g_stage
        logic                     r_vld;
        logic [2:0][NUM_BITS-1:0] r_rem, n_rem;
        logic [2:0][Q_BITS-1:0]   r_q,   n_q;
        logic [ROOT_BITS-1:0]     r_root;
        t_side                    r_side;

        // Subtract the shifted divisor wherever it fits.
        always_comb begin
            int                   k;
            logic [DREM_BITS-1:0] t;
            n_rem = w_rem[j];
            n_q   = w_q[j];
            for (int b = 0; b < DV_STEP; b++) begin
                k = Q_BITS - 1 - j * DV_STEP - b;
                t = '0;
                if (k >= 0) begin
                    t = DREM_BITS'(w_root[j]) << k;
                    for (int i = 0; i < 3; i++) begin
                        if (DREM_BITS'(n_rem[i]) >= t) begin
                            n_rem[i] = n_rem[i] - NUM_BITS'(t);
                            n_q[i]   = n_q[i] | (Q_BITS'(1) << k);
                        end
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else if (i_en) begin
                r_vld <= w_vld[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem  <= n_rem;
                r_q    <= n_q;
                r_root <= w_root[j];
                r_side <= w_side[j];
            end
        end

        assign w_vld[j+1]  = r_vld;
        assign w_rem[j+1]  = r_rem;
        assign w_q[j+1]    = r_q;
        assign w_root[j+1] = r_root;
        assign w_side[j+1] = r_side;
    end

    assign o_vld  = w_vld[DV_STAGES];
    assign o_q    = w_q[DV_STAGES];
    assign o_side = w_side[DV_STAGES];

endmodule

FILE: sv/camera_ray_direction_top.sv
`timescale 1ns / 1ps
// ============================================================================
// camera_ray_direction_top: primary ray direction of a pinhole camera.
// Pixel coordinate in, unit ray direction in signed Q1.14 out.
// ============================================================================
// The block takes one pixel transaction per clock and returns one direction
// transaction per pixel, in order: eight stages form the direction vector,
// normalize it and sum its squares, sixteen stages take the square root two
// bits at a time, eight stages divide two quotient bits at a time, and one
// output register holds the result. A stall on the output freezes the whole
// pipeline, so the input is ready whenever the output register is empty or
// being taken. Configuration must be written only while idle (not enforced).
module camera_ray_direction_top import crd_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    crd_pix_if.sink                  i_pix,
    crd_dir_if.source                o_dir,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_wdata
);

    t_cfg                   r_cfg;
    logic                   w_en;
    logic                   w_fr_vld, w_sq_vld, w_dv_vld;
    logic [SQ_BITS-1:0]     w_sum;
    t_norm_vec              w_fr_mag, w_sq_mag;
    t_side                  w_fr_side, w_sq_side, w_dv_side;
    logic [ROOT_BITS-1:0]   w_root;
    logic [2:0][Q_BITS-1:0] w_q;
    logic [2:0][COMP_BITS-1:0] n_dir;
    logic                   r_out_vld;
    logic [2:0][COMP_BITS-1:0] r_dir;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.basis_right      <= BASIS_BITS'(1) << FRAC_BITS;
            r_cfg.basis_up         <= BASIS_BITS'(1) << (COMP_BITS + FRAC_BITS);
            r_cfg.basis_back       <= BASIS_BITS'(1) << (2 * COMP_BITS + FRAC_BITS);
            r_cfg.scale_horizontal <= '0;
            r_cfg.scale_vertical   <= '0;
            r_cfg.half_width       <= '0;
            r_cfg.half_height      <= '0;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_BASIS_RIGHT: r_cfg.basis_right      <= i_cfg_wdata[BASIS_BITS-1:0];
                REG_BASIS_UP:    r_cfg.basis_up         <= i_cfg_wdata[BASIS_BITS-1:0];
                REG_BASIS_BACK:  r_cfg.basis_back       <= i_cfg_wdata[BASIS_BITS-1:0];
                REG_SCALE_H:     r_cfg.scale_horizontal <= i_cfg_wdata[SCALE_BITS-1:0];
                REG_SCALE_V:     r_cfg.scale_vertical   <= i_cfg_wdata[SCALE_BITS-1:0];
                REG_HALF_W:      r_cfg.half_width       <= i_cfg_wdata[HALF_BITS-1:0];
                REG_HALF_H:      r_cfg.half_height      <= i_cfg_wdata[HALF_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    // The pipeline advances whenever the output register can move.
    assign w_en        = !r_out_vld || o_dir.ready;
    assign i_pix.ready = w_en;

    crd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (i_pix.valid),
        .i_row   (i_pix.pixel_row),
        .i_col   (i_pix.pixel_col),
        .i_cfg   (r_cfg),
        .o_vld   (w_fr_vld),
        .o_sum   (w_sum),
        .o_mag   (w_fr_mag),
        .o_side  (w_fr_side)
    );

    crd_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_fr_vld),
        .i_sum   (w_sum),
        .i_mag   (w_fr_mag),
        .i_side  (w_fr_side),
        .o_vld   (w_sq_vld),
        .o_root  (w_root),
        .o_mag   (w_sq_mag),
        .o_side  (w_sq_side)
    );

    crd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_sq_vld),
        .i_root  (w_root),
        .i_mag   (w_sq_mag),
        .i_side  (w_sq_side),
        .o_vld   (w_dv_vld),
        .o_q     (w_q),
        .o_side  (w_dv_side)
    );

    // Clamp to one, apply the sign, and force zero for a zero direction.
    always_comb begin
        logic [Q_BITS-1:0] q;
        for (int i = 0; i < 3; i++) begin
            q = (w_q[i] > Q_ONE) ? Q_ONE : w_q[i];
            if (w_dv_side.zero) begin
                n_dir[i] = '0;
            end else if (w_dv_side.neg[i]) begin
                n_dir[i] = -COMP_BITS'(q);
            end else begin
                n_dir[i] = COMP_BITS'(q);
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= w_dv_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dir <= n_dir;
        end
    end

    assign o_dir.valid = r_out_vld;
    assign o_dir.dir_x = $signed(r_dir[0]);
    assign o_dir.dir_y = $signed(r_dir[1]);
    assign o_dir.dir_z = $signed(r_dir[2]);

    // Every component of a delivered direction stays within [-1, 1].
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_dir.valid |->
            (o_dir.dir_x >= -16384 && o_dir.dir_x <= 16384 &&
             o_dir.dir_y >= -16384 && o_dir.dir_y <= 16384 &&
             o_dir.dir_z >= -16384 && o_dir.dir_z <= 16384))
        else $error("direction component out of range");

    // A nonzero unit vector has a component of at least about 1/sqrt(3).
    a_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_dir.valid |->
            (o_dir.dir_x >= 9000 || o_dir.dir_x <= -9000 ||
             o_dir.dir_y >= 9000 || o_dir.dir_y <= -9000 ||
             o_dir.dir_z >= 9000 || o_dir.dir_z <= -9000 ||
             (o_dir.dir_x == 0 && o_dir.dir_y == 0 && o_dir.dir_z == 0)))
        else $error("direction is not normalized");

    // A held output blocks new pixel transactions.
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_dir.valid && !o_dir.ready) |-> !i_pix.ready)
        else $error("input accepted while output stalled");

    // A result only appears when the divider delivered an item.
    a_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_dir.valid) |-> $past(w_dv_vld))
        else $error("output valid without a divider result");

endmodule
